FILE: design/rvd_pkg.sv
// ----------------------------------------------------------------------------
// rvd_pkg
// Shared constants for the radial vignette darkening block.
// ----------------------------------------------------------------------------
`default_nettype none

package rvd_pkg;

  // Default pixel coordinate width
  localparam int COORD_WIDTH_DEF = 12;

  // Knee register width and channel width
  localparam int KNEE_WIDTH = 13;
  localparam int CHAN_WIDTH = 8;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_X    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Y    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_KNEE_RADIUS = 2'd2;

  // Reset values
  localparam int CENTER_RESET = 500;
  localparam int KNEE_RESET   = 100;

  // Distance scale 10/9
  localparam int DIST_NUM = 10;
  localparam int DIST_DEN = 9;

endpackage

`default_nettype wire

FILE: design/rvd_pix_if.sv
// ----------------------------------------------------------------------------
// rvd_pix_if
// Pixel input channel: coordinate and three color channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvd_pix_if #(
  parameter int COORD_WIDTH = rvd_pkg::COORD_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [COORD_WIDTH-1:0]         pixel_x;
  logic [COORD_WIDTH-1:0]         pixel_y;
  logic [rvd_pkg::CHAN_WIDTH-1:0] red_in;
  logic [rvd_pkg::CHAN_WIDTH-1:0] green_in;
  logic [rvd_pkg::CHAN_WIDTH-1:0] blue_in;

  modport source (output valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                  output ready);
endinterface

`default_nettype wire

FILE: design/rvd_rgb_if.sv
// ----------------------------------------------------------------------------
// rvd_rgb_if
// Result channel: three color channels after the vignette.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvd_rgb_if;
  logic                           valid;
  logic                           ready;
  logic [rvd_pkg::CHAN_WIDTH-1:0] red_out;
  logic [rvd_pkg::CHAN_WIDTH-1:0] green_out;
  logic [rvd_pkg::CHAN_WIDTH-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

FILE: design/rvd_cfg_if.sv
// ----------------------------------------------------------------------------
// rvd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rvd_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [rvd_pkg::CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/radial_vignette_darken_top.sv
// ----------------------------------------------------------------------------
// radial_vignette_darken_top
// Radial vignette: distance from a center, scaled by 10/9, darkens pixels
// beyond the knee by knee/distance.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the whole pipeline holds while the output
//   register is full and not taken.
// The depth is set by the square root (one stage per root bit) and the
//   channel divider (one stage per quotient bit).
// Reset: clears all stage valid bits and loads center 500/500 and knee 100.
`default_nettype none

module radial_vignette_darken_top #(
  parameter int COORD_WIDTH = rvd_pkg::COORD_WIDTH_DEF
) (
  input  wire        clk,
  input  wire        rst,
  rvd_cfg_if.sink    cfg,
  rvd_pix_if.sink    pix,
  rvd_rgb_if.source  rgb
);

  localparam int W    = COORD_WIDTH;
  localparam int CW   = rvd_pkg::CHAN_WIDTH;
  localparam int KW   = rvd_pkg::KNEE_WIDTH;
  localparam int PXW  = 3 * CW;              // packed color payload
  localparam int RTW  = W + 1;               // root bits
  localparam int VW   = 2 * RTW;             // radicand, padded to even
  localparam int REMW = W + 4;               // root remainder
  localparam int NW   = RTW + 4;             // root * 10
  localparam int K    = NW + 4;              // reciprocal shift
  localparam int MW   = K - 3;               // reciprocal width
  localparam longint unsigned RECIP = (64'd1 << K) / rvd_pkg::DIST_DEN;
  localparam int DW   = RTW + 1;             // scaled distance
  localparam int RW   = DW + CW;             // divider remainder
  localparam int PW   = CW + KW;             // channel * knee
  localparam int QN   = CW;                  // quotient bits

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [W-1:0]  center_x;
  logic [W-1:0]  center_y;
  logic [KW-1:0] knee_radius;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= W'(rvd_pkg::CENTER_RESET);
      center_y    <= W'(rvd_pkg::CENTER_RESET);
      knee_radius <= KW'(rvd_pkg::KNEE_RESET);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rvd_pkg::REG_CENTER_X:    center_x    <= cfg.data[W-1:0];
        rvd_pkg::REG_CENTER_Y:    center_y    <= cfg.data[W-1:0];
        rvd_pkg::REG_KNEE_RADIUS: knee_radius <= cfg.data[KW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: every stage moves when the output register frees up
  logic adv;
  logic [QN-1:0] dv_vld;

  assign adv       = !dv_vld[QN-1] || rgb.ready;
  assign pix.ready = adv;

  // ---------------------------------------------------------------------------
  // Stage: absolute offsets
  logic           in_vld;
  logic [W-1:0]   dx;
  logic [W-1:0]   dy;
  logic [PXW-1:0] in_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (adv) begin
      in_vld <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx    <= (pix.pixel_x >= center_x) ? pix.pixel_x - center_x : center_x - pix.pixel_x;
      dy    <= (pix.pixel_y >= center_y) ? pix.pixel_y - center_y : center_y - pix.pixel_y;
      in_px <= {pix.red_in, pix.green_in, pix.blue_in};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: squares
  logic           sqr_vld;
  logic [2*W-1:0] dx2;
  logic [2*W-1:0] dy2;
  logic [PXW-1:0] sqr_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      sqr_vld <= 1'b0;
    end else if (adv) begin
      sqr_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx2    <= dx * dx;
      dy2    <= dy * dy;
      sqr_px <= in_px;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: sum of squares
  logic           sum_vld;
  logic [VW-1:0]  sum_v;
  logic [PXW-1:0] sum_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else if (adv) begin
      sum_vld <= sqr_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_v  <= VW'(dx2) + VW'(dy2);
      sum_px <= sqr_px;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root: one stage per root bit, two radicand bits per stage
  logic [RTW-1:0] sq_vld;
  logic [REMW-1:0] sq_rem  [RTW];
  logic [RTW-1:0]  sq_root [RTW];
  logic [VW-1:0]   sq_v    [RTW];
  logic [PXW-1:0]  sq_px   [RTW];

  for (genvar i = 0; i < RTW; i++) begin : g_sqrt
    logic            prev_vld;
    logic [REMW-1:0] prev_rem;
    logic [RTW-1:0]  prev_root;
    logic [VW-1:0]   prev_v;
    logic [PXW-1:0]  prev_px;
    logic [REMW-1:0] trial_rem;
    logic [REMW-1:0] trial_sub;

    if (i == 0) begin : g_first
      assign prev_vld  = sum_vld;
      assign prev_rem  = '0;
      assign prev_root = '0;
      assign prev_v    = sum_v;
      assign prev_px   = sum_px;
    end else begin : g_next
      assign prev_vld  = sq_vld[i-1];
      assign prev_rem  = sq_rem[i-1];
      assign prev_root = sq_root[i-1];
      assign prev_v    = sq_v[i-1];
      assign prev_px   = sq_px[i-1];
    end

    // Bring down the next bit pair and try root*4+1
    assign trial_rem = {prev_rem[REMW-3:0], prev_v[2*(RTW-1-i)+1 -: 2]};
    assign trial_sub = REMW'({prev_root, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[i] <= 1'b0;
      end else if (adv) begin
        sq_vld[i] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_v[i]  <= prev_v;
        sq_px[i] <= prev_px;
        if (trial_rem >= trial_sub) begin
          sq_rem[i]  <= trial_rem - trial_sub;
          sq_root[i] <= {prev_root[RTW-2:0], 1'b1};
        end else begin
          sq_rem[i]  <= trial_rem;
          sq_root[i] <= {prev_root[RTW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: root * 10, times the reciprocal of 9
  logic            mul_vld;
  logic [NW-1:0]   mul_n;
  logic [NW+MW-1:0] mul_p;
  logic [PXW-1:0]  mul_px;
  logic [NW-1:0]   root10;

  assign root10 = (NW'(sq_root[RTW-1]) << 3) + (NW'(sq_root[RTW-1]) << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
    end else if (adv) begin
      mul_vld <= sq_vld[RTW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_n  <= root10;
      mul_p  <= (NW+MW)'(root10) * (NW+MW)'(MW'(RECIP));
      mul_px <= sq_px[RTW-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: correct the estimate by at most one
  logic           cor_vld;
  logic [DW-1:0]  sc_dist;
  logic [PXW-1:0] cor_px;
  logic [DW-1:0]  q_est;
  logic [NW-1:0]  q_rem;

  assign q_est = mul_p[K +: DW];
  assign q_rem = mul_n - NW'(q_est) * NW'(rvd_pkg::DIST_DEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      cor_vld <= 1'b0;
    end else if (adv) begin
      cor_vld <= mul_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_dist <= (q_rem >= NW'(rvd_pkg::DIST_DEN)) ? q_est + 1'b1 : q_est;
      cor_px  <= mul_px;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: knee compare and channel * knee products
  logic           prd_vld;
  logic           prd_dark;
  logic [DW-1:0]  prd_dist;
  logic [PXW-1:0] prd_px;
  logic [RW-1:0]  prd_num [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      prd_vld <= 1'b0;
    end else if (adv) begin
      prd_vld <= cor_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prd_dark <= (DW+KW)'(sc_dist) > (DW+KW)'(knee_radius);
      prd_dist <= sc_dist;
      prd_px   <= cor_px;
      for (int c = 0; c < 3; c++) begin
        prd_num[c] <= RW'(PW'(cor_px[CW*(2-c) +: CW]) * PW'(knee_radius));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Channel divider: one quotient bit per stage, three lanes
  logic           dv_dark [QN];
  logic [DW-1:0]  dv_dist [QN];
  logic [PXW-1:0] dv_px   [QN];
  logic [RW-1:0]  dv_rem  [QN][3];
  logic [CW-1:0]  dv_q    [QN][3];

  for (genvar s = 0; s < QN; s++) begin : g_div
    logic           prev_vld;
    logic           prev_dark;
    logic [DW-1:0]  prev_dist;
    logic [PXW-1:0] prev_px;
    logic [RW-1:0]  prev_rem [3];
    logic [CW-1:0]  prev_q   [3];
    logic [RW-1:0]  dsh;

    if (s == 0) begin : g_first
      assign prev_vld  = prd_vld;
      assign prev_dark = prd_dark;
      assign prev_dist = prd_dist;
      assign prev_px   = prd_px;
      for (genvar c = 0; c < 3; c++) begin : g_lane
        assign prev_rem[c] = prd_num[c];
        assign prev_q[c]   = '0;
      end
    end else begin : g_next
      assign prev_vld  = dv_vld[s-1];
      assign prev_dark = dv_dark[s-1];
      assign prev_dist = dv_dist[s-1];
      assign prev_px   = dv_px[s-1];
      for (genvar c = 0; c < 3; c++) begin : g_lane
        assign prev_rem[c] = dv_rem[s-1][c];
        assign prev_q[c]   = dv_q[s-1][c];
      end
    end

    // Divisor aligned to this quotient bit
    assign dsh = RW'(prev_dist) << (QN - 1 - s);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[s] <= 1'b0;
      end else if (adv) begin
        dv_vld[s] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_dark[s] <= prev_dark;
        dv_dist[s] <= prev_dist;
        dv_px[s]   <= prev_px;
        for (int c = 0; c < 3; c++) begin
          if (prev_rem[c] >= dsh) begin
            dv_rem[s][c] <= prev_rem[c] - dsh;
            dv_q[s][c]   <= {prev_q[c][CW-2:0], 1'b1};
          end else begin
            dv_rem[s][c] <= prev_rem[c];
            dv_q[s][c]   <= {prev_q[c][CW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output: quotient when darkened, else the original channels
  assign rgb.valid     = dv_vld[QN-1];
  assign rgb.red_out   = dv_dark[QN-1] ? dv_q[QN-1][0] : dv_px[QN-1][2*CW +: CW];
  assign rgb.green_out = dv_dark[QN-1] ? dv_q[QN-1][1] : dv_px[QN-1][CW +: CW];
  assign rgb.blue_out  = dv_dark[QN-1] ? dv_q[QN-1][2] : dv_px[QN-1][0 +: CW];

  // ---------------------------------------------------------------------------
  // Assertions
  logic [NW-1:0] prd_n_chk;
  always_ff @(posedge clk) begin
    if (adv) begin
      prd_n_chk <= mul_n;
    end
  end

  a_rst_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rgb.valid)
    else $error("output valid right after reset");

  a_sqrt_floor: assert property (@(posedge clk) disable iff (rst)
    sq_vld[RTW-1] |->
      ((VW+2)'(sq_root[RTW-1]) * (VW+2)'(sq_root[RTW-1]) <= (VW+2)'(sq_v[RTW-1])) &&
      (((VW+2)'(sq_root[RTW-1]) + 1'b1) * ((VW+2)'(sq_root[RTW-1]) + 1'b1) >
       (VW+2)'(sq_v[RTW-1])))
    else $error("square root not floor");

  a_scale_div: assert property (@(posedge clk) disable iff (rst)
    cor_vld |-> (NW+4)'(sc_dist) * (NW+4)'(rvd_pkg::DIST_DEN) <= (NW+4)'(prd_n_chk) &&
      (NW+4)'(prd_n_chk) < (NW+4)'(sc_dist) * (NW+4)'(rvd_pkg::DIST_DEN) +
      (NW+4)'(rvd_pkg::DIST_DEN))
    else $error("distance scaling off");

  a_dark_le: assert property (@(posedge clk) disable iff (rst)
    rgb.valid && dv_dark[QN-1] |->
      rgb.red_out <= dv_px[QN-1][2*CW +: CW] &&
      rgb.green_out <= dv_px[QN-1][CW +: CW] &&
      rgb.blue_out <= dv_px[QN-1][0 +: CW])
    else $error("darkened channel exceeds input");

endmodule

`default_nettype wire

FILE: dv/radial_vignette_darken_top_tb.sv
// ----------------------------------------------------------------------------
// radial_vignette_darken_top_tb
// Drives pixels through the vignette block with random gaps on both sides,
// predicts each output pixel from the current center and knee registers and
// compares it field by field. Registers change only while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module radial_vignette_darken_top_tb;

  localparam int CW = rvd_pkg::COORD_WIDTH_DEF;
  localparam int PIPE_DEPTH = CW + 15;

  // Index that maps to no register
  localparam logic [rvd_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [7:0]    r;
    logic [7:0]    g;
    logic [7:0]    b;
  } pixel_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Directed row: pixel plus an optional typed expectation
  typedef struct packed {
    pixel_t pix;
    logic   known;
    rgb_t   want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;

  rvd_cfg_if cfg ();
  rvd_pix_if #(.COORD_WIDTH(CW)) pix ();
  rvd_rgb_if rgb ();

  radial_vignette_darken_top #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst(rst), .cfg(cfg), .pix(pix), .rgb(rgb)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the vignette registers
  logic [CW-1:0] center_x_q = CW'(rvd_pkg::CENTER_RESET);
  logic [CW-1:0] center_y_q = CW'(rvd_pkg::CENTER_RESET);
  logic [rvd_pkg::KNEE_WIDTH-1:0] knee_q = rvd_pkg::KNEE_WIDTH'(rvd_pkg::KNEE_RESET);

  rgb_t expected_pixels[$];

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic rgb_t darken_pixel(pixel_t p);
    longint unsigned dx, dy, sdist;
    rgb_t o;
    dx = (p.px >= center_x_q) ? p.px - center_x_q : center_x_q - p.px;
    dy = (p.py >= center_y_q) ? p.py - center_y_q : center_y_q - p.py;
    sdist = floor_root(dx * dx + dy * dy) * rvd_pkg::DIST_NUM / rvd_pkg::DIST_DEN;
    o = '{p.r, p.g, p.b};
    if (sdist > knee_q) begin
      o.r = 8'(longint'(p.r) * knee_q / sdist);
      o.g = 8'(longint'(p.g) * knee_q / sdist);
      o.b = 8'(longint'(p.b) * knee_q / sdist);
    end
    return o;
  endfunction

  // Consumer: random stall, check each item against the oldest expectation
  initial begin
    int stall;
    rgb_t want;
    rgb.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      stall = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 3) stall = 0;
      if (stall > 0) begin
        rgb.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rgb.ready <= 1'b1;
      @(posedge clk iff rgb.valid);
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected item r=%0d g=%0d b=%0d", $time,
                 rgb.red_out, rgb.green_out, rgb.blue_out);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (rgb.red_out !== want.r) begin
          $display("%0t: red exp %0d got %0d", $time, want.r, rgb.red_out);
          errors++;
        end
        if (rgb.green_out !== want.g) begin
          $display("%0t: green exp %0d got %0d", $time, want.g, rgb.green_out);
          errors++;
        end
        if (rgb.blue_out !== want.b) begin
          $display("%0t: blue exp %0d got %0d", $time, want.b, rgb.blue_out);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [rvd_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           logic [rvd_pkg::CFG_DATA_WIDTH-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk iff cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      rvd_pkg::REG_CENTER_X:    center_x_q = val[CW-1:0];
      rvd_pkg::REG_CENTER_Y:    center_y_q = val[CW-1:0];
      rvd_pkg::REG_KNEE_RADIUS: knee_q = val[rvd_pkg::KNEE_WIDTH-1:0];
      default: ;
    endcase
    // Hold the channel idle between writes
    @(posedge clk);
  endtask

  // Drop the input and hold until the pipe has drained
  task automatic drain();
    pix.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  task automatic send_pixel(pixel_t p, logic known, rgb_t want, logic gaps);
    int gap;
    rgb_t got;
    gap = gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= p.px;
    pix.pixel_y <= p.py;
    pix.red_in  <= p.r;
    pix.green_in <= p.g;
    pix.blue_in <= p.b;
    got = darken_pixel(p);
    expected_pixels.push_back(known ? want : got);
    @(posedge clk iff pix.ready);
  endtask

  function automatic pixel_t rand_pixel(int reach);
    pixel_t p;
    int sx, sy;
    p.px = CW'($urandom);
    p.py = CW'($urandom);
    p.r = 8'($urandom); p.g = 8'($urandom); p.b = 8'($urandom);
    if (reach != 0) begin
      // stay near the center so darkening is partial
      sx = int'(center_x_q) + int'($urandom_range(0, 2 * reach)) - reach;
      sy = int'(center_y_q) + int'($urandom_range(0, 2 * reach)) - reach;
      p.px = CW'(sx < 0 ? 0 : sx);
      p.py = CW'(sy < 0 ? 0 : sy);
    end
    return p;
  endfunction

  row_t directed_rows[] = '{
    // center after reset passes unchanged
    '{'{12'd500, 12'd500, 8'd255, 8'd128, 8'd1}, 1'b1, '{8'd255, 8'd128, 8'd1}},
    '{'{12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{'{12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{'{12'd0, 12'd4095, 8'd255, 8'd0, 8'd255}, 1'b0, '0},
    '{'{12'd4095, 12'd0, 8'd170, 8'd85, 8'd255}, 1'b0, '0},
    '{'{12'd590, 12'd500, 8'd200, 8'd100, 8'd50}, 1'b0, '0},
    '{'{12'd591, 12'd500, 8'd200, 8'd100, 8'd50}, 1'b0, '0},
    '{'{12'd500, 12'd410, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{'{12'd501, 12'd501, 8'd10, 8'd20, 8'd30}, 1'b1, '{8'd10, 8'd20, 8'd30}}
  };

  initial begin
    int n;
    pixel_t p;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    pix.valid = 1'b0; pix.pixel_x = '0; pix.pixel_y = '0;
    pix.red_in = '0; pix.green_in = '0; pix.blue_in = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_pixel(directed_rows[i].pix, directed_rows[i].known,
                 directed_rows[i].want, 1'b1);
    drain();

    // Zero knee: off-center goes black, center passes
    write_reg(rvd_pkg::REG_KNEE_RADIUS, 16'd0);
    send_pixel('{12'd500, 12'd501, 8'd255, 8'd255, 8'd255}, 1'b1, '0, 1'b0);
    send_pixel('{12'd500, 12'd500, 8'd7, 8'd8, 8'd9}, 1'b1,
               '{8'd7, 8'd8, 8'd9}, 1'b0);
    drain();
    // Wide values and an unknown index
    write_reg(rvd_pkg::REG_CENTER_X, 16'hFFFF);
    write_reg(rvd_pkg::REG_CENTER_Y, 16'h0000);
    write_reg(rvd_pkg::REG_KNEE_RADIUS, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h1234);
    send_pixel('{12'd0, 12'd4095, 8'd255, 8'd1, 8'd77}, 1'b0, '0, 1'b0);
    send_pixel('{12'd4095, 12'd0, 8'd255, 8'd1, 8'd77}, 1'b0, '0, 1'b0);
    drain();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(rvd_pkg::REG_CENTER_X, 16'd0);
          write_reg(rvd_pkg::REG_CENTER_Y, 16'd4095);
          write_reg(rvd_pkg::REG_KNEE_RADIUS, 16'd1);
        end
        1: begin
          write_reg(rvd_pkg::REG_CENTER_X, 16'd4095);
          write_reg(rvd_pkg::REG_CENTER_Y, 16'd0);
          write_reg(rvd_pkg::REG_KNEE_RADIUS, 16'd8191);
        end
        default: begin
          write_reg(rvd_pkg::REG_CENTER_X, 16'($urandom));
          write_reg(rvd_pkg::REG_CENTER_Y, 16'($urandom));
          write_reg(rvd_pkg::REG_KNEE_RADIUS, 16'($urandom_range(0, 600)));
        end
      endcase
      n = 62;
      for (int k = 0; k < n; k++) begin
        p = rand_pixel(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 800));
        send_pixel(p, 1'b0, '0, (ph % 3) != 2);
      end
      drain();
    end

    if (errors == 0) begin
      $display("radial_vignette_darken_top_tb: done, clean");
    end else begin
      $display("radial_vignette_darken_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("radial_vignette_darken_top_tb: done, errors");
    $finish;
  end

endmodule

FILE: radial_vignette_darken_top.f
design/rvd_pkg.sv
design/rvd_pix_if.sv
design/rvd_rgb_if.sv
design/rvd_cfg_if.sv
design/radial_vignette_darken_top.sv
dv/radial_vignette_darken_top_tb.sv
